@@ hdl/plm_pkg.sv @@
// Package for the peak level meter: beat payload types, register indexes
// and fixed widths. Depends on nothing; every other file imports it.
package plm_pkg;

    localparam int SMP_W      = 16;
    localparam int PEAK_W     = 31;
    localparam int LED_MAX    = 4;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW   = 2'd2;

    localparam logic [PEAK_W-1:0] DECAY_RESET = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    block_end;
    } t_in_beat;

    typedef struct packed {
        logic [LED_MAX-1:0] led_on;
        logic [PEAK_W-1:0]  peak_level;
    } t_out_beat;

    // Decayed peak of a block's last sample, handed to the LED stage.
    typedef struct packed {
        logic              valid;
        logic [PEAK_W-1:0] peak;
    } t_peak_beat;

endpackage

@@ hdl/plm_in_if.sv @@
// Sample channel: valid/ready handshake carrying one audio sample per beat.
// Depends on plm_pkg.
interface plm_in_if import plm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/plm_out_if.sv @@
// Result channel: valid/ready handshake carrying LED bits and peak level.
// Depends on plm_pkg.
interface plm_out_if import plm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/plm_peak.sv @@
// Input register (sample magnitude) and peak memory with multiplicative decay.
// Depends on plm_pkg.
module plm_peak import plm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  t_in_beat          i_beat,
    input  logic [PEAK_W-1:0] i_decay,
    input  logic              i_next_free,
    output logic              o_ready,
    output t_peak_beat        o_beat
);

    logic              r_a_valid;
    logic              r_a_end;
    logic [PEAK_W-1:0] r_a_mag;
    logic              r_b_valid;
    logic              r_b_end;
    logic [PEAK_W-1:0] r_peak;

    logic [SMP_W-1:0]     abs_smp;
    logic [SMP_W-2:0]     mag_hi;
    logic [PEAK_W-1:0]    n_a_mag;
    logic [PEAK_W-1:0]    peak_max;
    logic [2*PEAK_W-1:0]  prod;
    logic [PEAK_W-1:0]    n_peak;
    logic                 a_free;
    logic                 b_free;

    // Only the most negative sample overflows the 15-bit magnitude.
    always_comb begin
        abs_smp = i_beat.sample[SMP_W-1] ? (~i_beat.sample + 16'd1) : i_beat.sample;
        mag_hi  = abs_smp[SMP_W-1] ? {(SMP_W-1){1'b1}} : abs_smp[SMP_W-2:0];
        n_a_mag = {mag_hi, {THR_W{1'b0}}};
    end

    always_comb begin
        peak_max = (r_a_mag > r_peak) ? r_a_mag : r_peak;
        prod     = peak_max * i_decay;
        n_peak   = {prod[2*PEAK_W-1:32], 1'b0};
    end

    // A stage-B item that is not a block end produces no result and simply retires.
    assign b_free  = !r_b_valid || !r_b_end || i_next_free;
    assign a_free  = !r_a_valid || b_free;
    assign o_ready = a_free;

    assign o_beat.valid = r_b_valid && r_b_end;
    assign o_beat.peak  = r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_peak    <= '0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_take;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
                if (r_a_valid) begin
                    r_peak <= n_peak;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free && i_take) begin
            r_a_mag <= n_a_mag;
            r_a_end <= i_beat.block_end;
        end
        if (b_free && r_a_valid) begin
            r_b_end <= r_a_end;
        end
    end

endmodule

@@ hdl/plm_leds.sv @@
// LED hysteresis update and result register.
// Depends on plm_pkg and plm_out_if.
module plm_leds import plm_pkg::*; #(
    parameter int NUM_LEDS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_peak_beat            i_beat,
    input  logic [CFG_DATA_W-1:0] i_high,
    input  logic [CFG_DATA_W-1:0] i_low,
    output logic                  o_free,
    plm_out_if.source             o_res
);

    logic               r_valid;
    logic [LED_MAX-1:0] r_led;
    logic [PEAK_W-1:0]  r_peak;
    logic [LED_MAX-1:0] n_led;

    logic signed [PEAK_W+1:0] peak_s;
    logic signed [PEAK_W+1:0] hi_thr;
    logic signed [PEAK_W+1:0] lo_thr;

    // Thresholds are signed upper halves of a 32-bit word; compare at 33 bits.
    always_comb begin
        n_led  = r_led;
        peak_s = $signed({2'b00, i_beat.peak});
        hi_thr = '0;
        lo_thr = '0;
        for (int i = 0; i < LED_MAX; i++) begin
            hi_thr = $signed({i_high[i*THR_W+THR_W-1], i_high[i*THR_W +: THR_W],
                              {THR_W{1'b0}}});
            lo_thr = $signed({i_low[i*THR_W+THR_W-1], i_low[i*THR_W +: THR_W],
                              {THR_W{1'b0}}});
            if (i < NUM_LEDS) begin
                if (peak_s > hi_thr) begin
                    n_led[i] = 1'b1;
                end else if (peak_s < lo_thr) begin
                    n_led[i] = 1'b0;
                end
            end
        end
    end

    assign o_free = !r_valid || o_res.ready;

    assign o_res.valid           = r_valid;
    assign o_res.data.led_on     = r_led;
    assign o_res.data.peak_level = r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_led   <= '0;
        end else if (o_free) begin
            r_valid <= i_beat.valid;
            if (i_beat.valid) begin
                r_led <= n_led;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_beat.valid) begin
            r_peak <= i_beat.peak;
        end
    end

endmodule

@@ hdl/peak_level_meter_with_hysteresis.sv @@
// Peak level meter with hysteresis LED outputs: top level, configuration
// registers and assertions. Depends on plm_pkg, plm_in_if, plm_out_if,
// plm_peak and plm_leds.
//
//   Channel  Direction  Beat contents                 Handshake
//   i_smp    in         sample (s16), block_end (1)   valid/ready
//   o_res    out        led_on (4), peak_level (31)   valid/ready
//   i_cfg_*  in         index (2), data (64)          write enable only
//
// One sample is taken every clock cycle unless a block end waits on a stalled
// result. A block's last sample passes the magnitude register, then the peak
// register (one 31x31 multiply), then the result register, which takes the
// LED compare result.
// Reset is synchronous and active low; it clears the peak memory, the LEDs,
// all valid flags and both thresholds, and loads the decay factor with all ones.
// A stalled result holds the pipeline; samples that end no block keep
// flowing until a block end meets the full result register.
module peak_level_meter_with_hysteresis import plm_pkg::*; #(
    parameter int NUM_LEDS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    plm_in_if.sink                i_smp,
    plm_out_if.source             o_res,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [PEAK_W-1:0]     r_decay;
    logic [CFG_DATA_W-1:0] r_high;
    logic [CFG_DATA_W-1:0] r_low;

    t_peak_beat peak_beat;
    logic       led_free;
    logic       take;

    // Register file. Index three falls into the default arm and is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= DECAY_RESET;
            r_high  <= '0;
            r_low   <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_DECAY: r_decay <= i_cfg_data[PEAK_W-1:0];
                REG_HIGH:  r_high  <= i_cfg_data;
                REG_LOW:   r_low   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign take = i_smp.valid && i_smp.ready;

    // Magnitude and the decaying peak memory.
    plm_peak u_peak (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_beat      (i_smp.data),
        .i_decay     (r_decay),
        .i_next_free (led_free),
        .o_ready     (i_smp.ready),
        .o_beat      (peak_beat)
    );

    // Hysteresis on the block-end peak, and the result register.
    plm_leds #(
        .NUM_LEDS (NUM_LEDS)
    ) u_leds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (peak_beat),
        .i_high  (r_high),
        .i_low   (r_low),
        .o_free  (led_free),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    // The input side only stalls behind a held result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_smp.ready |-> (o_res.valid && !o_res.ready))
        else $error("sample input stalled without a held result");

    // LEDs beyond the configured count never light.
    a_unused_leds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.data.led_on >> NUM_LEDS) == '0))
        else $error("unused LED bit set");

    // A result appears only after a block-end peak was offered to the LED stage.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !$past(o_res.valid)) |-> $past(peak_beat.valid))
        else $error("result without a block-end peak");
`endif

endmodule

@@ bench/plm_level_check.sv @@
// Level checker for the peak level meter: tracks sample and result beats,
// predicts LED bits and peak level, and counts mismatches.
// Depends on plm_pkg, plm_in_if and plm_out_if.
module plm_level_check import plm_pkg::*; #(
    parameter int NUM_LEDS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    plm_in_if                     i_smp,
    plm_out_if                    i_res,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_err_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PEAK_W-1:0]     decay_q;
    logic [CFG_DATA_W-1:0] high_q;
    logic [CFG_DATA_W-1:0] low_q;
    logic [PEAK_W-1:0]     peak_q;
    logic [LED_MAX-1:0]    leds_q;
    t_out_beat             level_q[$];

    // Magnitude in the upper half of a 32-bit word; -32768 saturates.
    function automatic logic [31:0] mag_word(input logic [SMP_W-1:0] s);
        logic [16:0] m;
        m = s[SMP_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
        if (m > 17'h07FFF) begin
            m = 17'h07FFF;
        end
        return {m[15:0], 16'h0000};
    endfunction

    function automatic logic [PEAK_W-1:0] decayed_peak(input logic [PEAK_W-1:0] peak,
                                                       input logic [31:0] mag,
                                                       input logic [PEAK_W-1:0] decay);
        logic [31:0] held;
        logic [61:0] prod;
        held = (mag > {1'b0, peak}) ? mag : {1'b0, peak};
        prod = 62'(held[PEAK_W-1:0]) * 62'(decay);
        return {prod[61:32], 1'b0};
    endfunction

    // Threshold field taken as the signed upper half of a 32-bit word.
    function automatic logic signed [47:0] led_level(input logic [CFG_DATA_W-1:0] levels,
                                                     input int idx);
        logic [THR_W-1:0] f;
        f = levels[THR_W*idx +: THR_W];
        return {{16{f[THR_W-1]}}, f, 16'h0000};
    endfunction

    function automatic logic [LED_MAX-1:0] hysteresis_leds(input logic [LED_MAX-1:0] leds,
                                                           input logic [PEAK_W-1:0] peak);
        logic signed [47:0] p;
        logic [LED_MAX-1:0] nxt;
        p = {17'b0, peak};
        nxt = leds;
        for (int i = 0; i < NUM_LEDS && i < LED_MAX; i++) begin
            if (p > led_level(high_q, i)) begin
                nxt[i] = 1'b1;
            end else if (p < led_level(low_q, i)) begin
                nxt[i] = 1'b0;
            end
        end
        return nxt;
    endfunction

    always @(posedge i_clk) begin : track
        t_out_beat want;
        t_out_beat got;
        if (!i_rst_n) begin
            decay_q   = DECAY_RESET;
            high_q    = '0;
            low_q     = '0;
            peak_q    = '0;
            leds_q    = '0;
            level_q.delete();
            o_err_cnt = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_DECAY: decay_q = i_cfg_data[PEAK_W-1:0];
                    REG_HIGH:  high_q  = i_cfg_data;
                    REG_LOW:   low_q   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                if (level_q.size() == 0) begin
                    if (o_err_cnt < 10) begin
                        $display("%0t: result beat with nothing outstanding:",
                                 $realtime, " led_on=%h peak=%h",
                                 got.led_on, got.peak_level);
                    end
                    o_err_cnt++;
                end else begin
                    want = level_q.pop_front();
                    if (got.led_on !== want.led_on || got.peak_level !== want.peak_level) begin
                        if (o_err_cnt < 10) begin
                            $display("%0t: mismatch: expected led_on=%h peak=%h,",
                                     $realtime, want.led_on, want.peak_level,
                                     " got led_on=%h peak=%h",
                                     got.led_on, got.peak_level);
                        end
                        o_err_cnt++;
                    end
                end
            end
            if (i_smp.valid && i_smp.ready) begin
                peak_q = decayed_peak(peak_q, mag_word(i_smp.data.sample), decay_q);
                if (i_smp.data.block_end) begin
                    leds_q = hysteresis_leds(leds_q, peak_q);
                    want.led_on     = leds_q;
                    want.peak_level = peak_q;
                    level_q.push_back(want);
                end
            end
        end
        o_pending = level_q.size();
    end

endmodule

@@ bench/tb_peak_level_meter_with_hysteresis.sv @@
// Testbench top for the peak level meter: clock, reset, sample stimulus,
// register writes, result back-pressure and the final verdict.
// Depends on plm_pkg, plm_in_if, plm_out_if, plm_level_check and the block.
module tb_peak_level_meter_with_hysteresis;
    import plm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LEDS = 4;
    // Index 3 maps to no register; writes there must leave all state alone.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 200000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    pending;
    int                    err_cnt;

    // Shared knobs between the sample driver and the result sink.
    bit idle_on;
    bit hold_req;

    plm_in_if  smp_if ();
    plm_out_if res_if ();

    peak_level_meter_with_hysteresis #(
        .NUM_LEDS(NUM_LEDS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp       (smp_if),
        .o_res       (res_if),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    plm_level_check #(
        .NUM_LEDS(NUM_LEDS)
    ) level_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp       (smp_if),
        .i_res       (res_if),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_err_cnt   (err_cnt)
    );

    // 8 ns clock period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case the block wedges and the drain never finishes.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("peak_level_meter_with_hysteresis verification failed");
        $finish;
    end

    // Result sink. Ready changes only at the falling edge. Short random stall
    // bursts happen while idle_on is set; a hold request drops ready for a
    // long stretch so that the pipeline fills and the sample input stalls.
    initial begin : result_sink
        int stall_left;
        stall_left   = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 5);
            end
            if (stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left--;
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    // Offer one sample beat and hold it until it is taken. Called and left at
    // a falling edge; valid stays high so back-to-back beats need no gap.
    task automatic send_beat(input logic [SMP_W-1:0] s, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            smp_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp_if.valid           = 1'b1;
        smp_if.data.sample     = s;
        smp_if.data.block_end  = last;
        do begin
            @(posedge i_clk);
        end while (!smp_if.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // Stop sending, wait for every outstanding result, then give samples that
    // end no block time to clear the three-stage pipeline before any write.
    task automatic settle();
        smp_if.valid = 1'b0;
        wait (pending == 0);
        repeat (6) @(negedge i_clk);
    endtask

    // Mostly samples under a per-block envelope so the peak moves around the
    // thresholds, plus raw random words and the extreme codes.
    function automatic logic [SMP_W-1:0] pick_sample(input int amp);
        logic [SMP_W-1:0] mag;
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            mag = 16'($urandom_range(0, amp));
            return ($urandom_range(0, 1) == 1) ? -mag : mag;
        end else if (r < 9) begin
            return 16'($urandom);
        end
        case ($urandom_range(0, 3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // New decay and thresholds for a random phase. The first two phases take
    // the decay extremes; the rest mix a full random word with slow decays.
    task automatic random_config(input int phase);
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] lo;
        logic [THR_W-1:0]      lo16;
        int                    mode;
        case (phase)
            0:       write_reg(REG_DECAY, 64'(DECAY_RESET));
            1:       write_reg(REG_DECAY, 64'd0);
            2:       write_reg(REG_DECAY, {$urandom, $urandom});
            default: write_reg(REG_DECAY, 64'($urandom_range(32'h7E00_0000, 32'h7FFF_FFFF)));
        endcase
        mode = $urandom_range(0, 2);
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        for (int i = 0; i < LED_MAX && mode != 0; i++) begin
            if (mode == 1) begin
                // Proper hysteresis band: low at or below high, both positive.
                lo16 = 16'($urandom_range(0, 16'h6FFF));
                lo[THR_W*i +: THR_W] = lo16;
                hi[THR_W*i +: THR_W] = lo16 + 16'($urandom_range(0, 16'h1000));
            end else begin
                hi[THR_W*i +: THR_W] = 16'($urandom_range(0, 16'h7FFF));
            end
        end
        write_reg(REG_HIGH, hi);
        write_reg(REG_LOW, lo);
    endtask

    // Random blocks of samples, mostly short, now and then a long one.
    task automatic random_phase(input int n_items);
        int sent;
        int len;
        int amp;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            amp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'h0FFF)
                                               : $urandom_range(0, 16'h7FFF);
            for (int j = 0; j < len; j++) begin
                send_beat(pick_sample(amp), j == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin : stimulus
        smp_if.valid = 1'b0;
        smp_if.data  = '0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset settings: slowest decay and zero thresholds. A zero peak sits
        // exactly on both thresholds and holds the LEDs off; any nonzero peak
        // lights all of them. Covers both full-scale codes, the saturating
        // most negative sample and alternating bit patterns.
        send_beat(16'h0000, 1'b1);
        send_beat(16'h7FFF, 1'b1);
        send_beat(16'h8000, 1'b1);
        send_beat(16'h8001, 1'b0);
        send_beat(16'h0001, 1'b1);
        send_beat(16'hFFFF, 1'b1);
        send_beat(16'h5555, 1'b0);
        send_beat(16'hAAAA, 1'b1);
        settle();

        // Zero decay keeps the peak at zero. LED 3 has a negative high level
        // and stays lit; LED 2 has a negative low level and never goes dark;
        // LED 1 has a low level just above zero and turns off.
        write_reg(REG_DECAY, 64'd0);
        write_reg(REG_HIGH, {16'h8000, 16'h7FFF, 16'h0000, 16'h0000});
        write_reg(REG_LOW,  {16'h0000, 16'h8000, 16'h0001, 16'h0000});
        send_beat(16'h7FFF, 1'b1);
        send_beat(16'h8000, 1'b1);
        send_beat(16'h0000, 1'b1);
        settle();

        // Decay of one half, written with junk above bit 30 that must be
        // dropped. A write to the unused index must change nothing. A loud
        // block lights the lower LEDs, then silence lets them fall below
        // their low levels.
        write_reg(REG_DECAY, 64'hFFFF_FFFF_C000_0000);
        write_reg(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_HIGH, 64'h7FFF_4000_2000_1000);
        write_reg(REG_LOW,  64'h6000_3000_1000_0800);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h7FFF, 1'b1);
        send_beat(16'h0000, 1'b0);
        send_beat(16'h0000, 1'b0);
        send_beat(16'h0000, 1'b0);
        send_beat(16'h0000, 1'b1);
        send_beat(16'h8000, 1'b1);

        // Random phases, each under its own settings. Phase 2 opens with a
        // long result hold-off while samples keep coming. Every phase ends
        // with a full drain, and the last one runs without any idling.
        for (int phase = 0; phase < 6; phase++) begin
            settle();
            random_config(phase);
            idle_on = (phase != 5);
            if (phase == 2) begin
                hold_req = 1'b1;
            end
            random_phase(150);
        end

        smp_if.valid = 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("peak_level_meter_with_hysteresis verification clean");
        end else begin
            $display("peak_level_meter_with_hysteresis verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/plm_pkg.sv
hdl/plm_in_if.sv
hdl/plm_out_if.sv
hdl/plm_peak.sv
hdl/plm_leds.sv
hdl/peak_level_meter_with_hysteresis.sv
bench/plm_level_check.sv
bench/tb_peak_level_meter_with_hysteresis.sv
